[rtl/vgrt_pkg.sv]
`default_nettype none
package vgrt_pkg;
	localparam int GridDim = 16;
	localparam int IdxW = 4;
	localparam int AddrW = 3 * IdxW;
	localparam int Depth = GridDim * GridDim * GridDim;
	localparam int ValueW = 16;
	localparam int EntryW = ValueW + 1;
	localparam int TW = 40;
	localparam logic [TW-1:0] TSat = {TW{1'b1}};
	// Voxel coordinate with one guard bit on each side of the grid.
	localparam int CW = IdxW + 2;
	localparam int NumW = 28;
	localparam int DenW = 15;
	localparam int QW = 40;

	localparam logic [1:0] RegX = 2'd0;
	localparam logic [1:0] RegY = 2'd1;
	localparam logic [1:0] RegZ = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_DIV_START, ST_DIV_WAIT, ST_READ, ST_CHECK, ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic [NumW-1:0] num;
		logic [DenW:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [QW-1:0] quo;
	} div_rsp_t;
endpackage
`default_nettype wire

[rtl/vgrt_ram.sv]
`default_nettype none
module vgrt_ram #(
	parameter int Width = 17,
	parameter int Depth = 4096
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[rtl/vgrt_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle. The numerator is scaled by
// 2^12 inside, so the quotient is num * 4096 / den.
module vgrt_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire vgrt_pkg::div_req_t req,
	output vgrt_pkg::div_rsp_t rsp
);
	localparam int DW = vgrt_pkg::QW;
	logic [DW-1:0] quo_q;
	logic [vgrt_pkg::DenW:0] rem_q;
	logic [vgrt_pkg::DenW:0] den_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [vgrt_pkg::DenW+1:0] trial;

	assign trial = {rem_q, quo_q[DW-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q <= 6'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= {req.num, 12'd0};
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[vgrt_pkg::DenW+1]) begin
				rem_q <= trial[vgrt_pkg::DenW:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[vgrt_pkg::DenW-1:0], quo_q[DW-1]};
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = busy_q && (cnt_q == 6'd1);
	assign rsp.quo = trial[vgrt_pkg::DenW+1] ? {quo_q[DW-2:0], 1'b0}
		: {quo_q[DW-2:0], 1'b1};
endmodule
`default_nettype wire

[rtl/voxel_grid_ray_traversal.sv]
`default_nettype none
// Channel  | Handshake              | Payload
// command  | start / busy           | mode, wr_*, start_*, dir_*
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
// result   | result_valid (strobe)  | hit, hit_value, hit_x, hit_y, hit_z
//
// After reset the voxel store is cleared one entry per cycle, with busy held
// high. A write item is stored in the done state. A trace item runs six
// serial divisions (tDelta and tMax for three axes on one shared divider),
// then visits one voxel at a time through the READ and CHECK states, bound by
// the single read port of the store, and then reports. Results cannot be
// stalled: each item gives one result_valid strobe of one cycle.
module voxel_grid_ray_traversal (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic mode,
	input wire logic [3:0] wr_x,
	input wire logic [3:0] wr_y,
	input wire logic [3:0] wr_z,
	input wire logic wr_present,
	input wire logic [15:0] wr_value,
	input wire logic signed [15:0] start_x,
	input wire logic signed [15:0] start_y,
	input wire logic signed [15:0] start_z,
	input wire logic signed [15:0] dir_x,
	input wire logic signed [15:0] dir_y,
	input wire logic signed [15:0] dir_z,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data,
	output logic result_valid,
	output logic hit,
	output logic [15:0] hit_value,
	output logic [3:0] hit_x,
	output logic [3:0] hit_y,
	output logic [3:0] hit_z
);
	localparam int AW = vgrt_pkg::AddrW;
	localparam int TW = vgrt_pkg::TW;
	localparam int CW = vgrt_pkg::CW;

	vgrt_pkg::state_t state_q, state_d;

	logic [15:0] cs_q [3];
	logic [15:0] st_q [3];
	logic signed [15:0] dr_q [3];
	logic signed [CW-1:0] pos_q [3];
	logic [TW-1:0] tmax_q [3];
	logic [TW-1:0] tdel_q [3];
	logic [2:0] div_idx_q;
	logic [AW:0] clr_q;
	logic result_q, hit_q;
	logic [15:0] hval_q;
	logic [3:0] hx_q, hy_q, hz_q;

	// Command latched for write items.
	logic wmode_q;
	logic [AW-1:0] waddr_q;
	logic [vgrt_pkg::EntryW-1:0] wdata_q;

	logic accept;
	assign accept = start && !busy;
	assign busy = (state_q != vgrt_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q[0] <= 16'd256;
			cs_q[1] <= 16'd256;
			cs_q[2] <= 16'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				vgrt_pkg::RegX: cs_q[0] <= cfg_data;
				vgrt_pkg::RegY: cs_q[1] <= cfg_data;
				vgrt_pkg::RegZ: cs_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Division operand selection: even index is tDelta, odd is tMax.
	logic [1:0] ax;
	logic signed [15:0] dsel;
	logic [15:0] mag;
	logic [15:0] sb;
	logic [11:0] gap;
	logic [27:0] prod;
	vgrt_pkg::div_req_t dreq;
	vgrt_pkg::div_rsp_t drsp;

	assign ax = div_idx_q[2:1];
	assign dsel = dr_q[ax];
	assign mag = dsel[15] ? 16'(-dsel) : 16'(dsel);
	assign sb = st_q[ax] ^ 16'h8000;
	assign gap = dsel[15] ? {1'b0, sb[10:0]} : (12'd2048 - {1'b0, sb[10:0]});
	assign prod = 28'(gap) * 28'(cs_q[ax]);

	always_comb begin
		dreq.start = (state_q == vgrt_pkg::ST_DIV_START);
		dreq.den = mag;
		// cs<<22 = (cs<<10)<<12 ; dist*cs<<11 = ((dist*cs)>>1)<<12 loses a bit,
		// so tMax is formed as (dist*cs<<12)/mag then halved.
		dreq.num = div_idx_q[0] ? prod : {2'd0, cs_q[ax], 10'd0};
	end

	vgrt_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// Memory.
	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [vgrt_pkg::EntryW-1:0] ram_wdata, ram_rdata;

	assign ram_we = (state_q == vgrt_pkg::ST_CLEAR) || (state_q == vgrt_pkg::ST_DONE && wmode_q);
	assign ram_waddr = (state_q == vgrt_pkg::ST_CLEAR) ? clr_q[AW-1:0] : waddr_q;
	assign ram_wdata = (state_q == vgrt_pkg::ST_CLEAR) ? '0 : wdata_q;
	assign ram_raddr = {pos_q[2][3:0], pos_q[1][3:0], pos_q[0][3:0]};

	vgrt_ram #(.Width(vgrt_pkg::EntryW), .Depth(vgrt_pkg::Depth)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	// Traversal decisions.
	logic outside;
	logic sel_x, sel_y;
	logic [1:0] sel;
	logic [TW:0] tsum;
	always_comb begin
		outside = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (pos_q[i] < 0 || pos_q[i] > CW'(signed'(vgrt_pkg::GridDim - 1))) outside = 1'b1;
		end
		sel_x = (tmax_q[0] < tmax_q[1]) && (tmax_q[0] < tmax_q[2]);
		sel_y = !(tmax_q[0] < tmax_q[1]) && (tmax_q[1] < tmax_q[2]);
		sel = sel_x ? 2'd0 : (sel_y ? 2'd1 : 2'd2);
		tsum = {1'b0, tmax_q[sel]} + {1'b0, tdel_q[sel]};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			vgrt_pkg::ST_CLEAR:
				if (clr_q == (AW+1)'(vgrt_pkg::Depth - 1)) state_d = vgrt_pkg::ST_IDLE;
			vgrt_pkg::ST_IDLE:
				if (accept) state_d = mode ? vgrt_pkg::ST_DIV_START : vgrt_pkg::ST_DONE;
			vgrt_pkg::ST_DIV_START: state_d = vgrt_pkg::ST_DIV_WAIT;
			vgrt_pkg::ST_DIV_WAIT:
				if (drsp.done) state_d = (div_idx_q == 3'd5) ? vgrt_pkg::ST_READ
					: vgrt_pkg::ST_DIV_START;
			vgrt_pkg::ST_READ:
				state_d = outside ? vgrt_pkg::ST_DONE : vgrt_pkg::ST_CHECK;
			vgrt_pkg::ST_CHECK:
				state_d = ram_rdata[vgrt_pkg::EntryW-1] ? vgrt_pkg::ST_DONE : vgrt_pkg::ST_READ;
			vgrt_pkg::ST_DONE: state_d = vgrt_pkg::ST_IDLE;
			default: state_d = vgrt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vgrt_pkg::ST_CLEAR;
			clr_q <= '0;
			div_idx_q <= '0;
			result_q <= 1'b0;
		end else begin
			state_q <= state_d;
			result_q <= (state_q == vgrt_pkg::ST_DONE);
			if (state_q == vgrt_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (accept) div_idx_q <= '0;
			else if (state_q == vgrt_pkg::ST_DIV_WAIT && drsp.done) div_idx_q <= div_idx_q + 3'd1;
		end
	end

	logic [TW:0] q_adj;
	assign q_adj = div_idx_q[0] ? {2'd0, drsp.quo[TW-1:1]} : {1'b0, drsp.quo};

	always_ff @(posedge clk) begin
		if (accept) begin
			wmode_q <= !mode;
			waddr_q <= {wr_z, wr_y, wr_x};
			wdata_q <= {wr_present, wr_value};
			st_q[0] <= start_x; st_q[1] <= start_y; st_q[2] <= start_z;
			dr_q[0] <= dir_x; dr_q[1] <= dir_y; dr_q[2] <= dir_z;
			pos_q[0] <= CW'(signed'(start_x >>> 11));
			pos_q[1] <= CW'(signed'(start_y >>> 11));
			pos_q[2] <= CW'(signed'(start_z >>> 11));
			hit_q <= 1'b0; hval_q <= '0; hx_q <= '0; hy_q <= '0; hz_q <= '0;
		end
		if (state_q == vgrt_pkg::ST_DIV_WAIT && drsp.done) begin
			if (dsel == 16'sd0) begin
				if (div_idx_q[0]) tmax_q[ax] <= vgrt_pkg::TSat;
				else tdel_q[ax] <= vgrt_pkg::TSat;
			end else if (div_idx_q[0]) begin
				tmax_q[ax] <= q_adj[TW-1:0];
			end else begin
				tdel_q[ax] <= q_adj[TW-1:0];
			end
		end
		if (state_q == vgrt_pkg::ST_CHECK) begin
			if (ram_rdata[vgrt_pkg::EntryW-1]) begin
				hit_q <= 1'b1;
				hval_q <= ram_rdata[15:0];
				hx_q <= pos_q[0][3:0]; hy_q <= pos_q[1][3:0]; hz_q <= pos_q[2][3:0];
			end else begin
				// A positive direction steps up; zero and negative step down.
				pos_q[sel] <= dr_q[sel] > 0 ? pos_q[sel] + CW'(1)
					: pos_q[sel] - CW'(1);
				tmax_q[sel] <= (tmax_q[sel] == vgrt_pkg::TSat || tdel_q[sel] == vgrt_pkg::TSat
					|| tsum[TW] || tsum[TW-1:0] == vgrt_pkg::TSat) ? vgrt_pkg::TSat
					: tsum[TW-1:0];
			end
		end
	end

	assign result_valid = result_q;
	assign hit = hit_q;
	assign hit_value = hval_q;
	assign hit_x = hx_q;
	assign hit_y = hy_q;
	assign hit_z = hz_q;

	a_busy_acc: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy) else $error("busy not raised after accept");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result strobe longer than one cycle");
	a_hit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy) else $error("result while busy");
endmodule
`default_nettype wire
